/* hdl/wmsm_pkg.sv */
// Shared constants and types for the windowed mean / stability monitor.
// No dependencies; imported by every module of the block.
package wmsm_pkg;

	localparam int WINDOW   = 64;                 // ring depth, 2..64
	localparam int SAMPLE_W = 24;
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 30;
	localparam int SQ_W     = 54;
	localparam int STAB_W   = 20;
	localparam int MUL_W    = 32;

	// compare-subtract unit
	localparam int SRC_W  = 62;                   // bits fed MSB first
	localparam int REM_W  = 32;                   // partial remainder
	localparam int RES_W  = 31;                   // root / quotient bits
	localparam int STEP_W = 5;

	localparam logic CSU_DIV  = 1'b0;
	localparam logic CSU_ROOT = 1'b1;

	typedef struct packed {
		logic              start;
		logic              op;        // CSU_DIV or CSU_ROOT
		logic [SRC_W-1:0]  src;       // left aligned dividend / radicand bits
		logic [REM_W-1:0]  rem_init;
		logic [SUM_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} csu_req_t;

	typedef struct packed {
		logic             done;       // one-cycle pulse, res valid
		logic [RES_W-1:0] res;
	} csu_rsp_t;

endpackage

/* hdl/wmsm_mul.sv */
// Shared 32x32 multiplier with registered product.
// Depends on wmsm_pkg.
module wmsm_mul
	import wmsm_pkg::*;
(
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

/* hdl/wmsm_csu.sv */
// Iterative compare-subtract unit: restoring integer square root (two bits
// a step) and restoring division (one bit a step). Depends on wmsm_pkg.
module wmsm_csu
	import wmsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  csu_req_t req,
	output csu_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic              op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SRC_W-1:0]  src_q;
	logic [REM_W-1:0]  rem_q;
	logic [RES_W-1:0]  res_q;
	logic [SUM_W-1:0]  div_q;

	logic [REM_W+1:0]  x_op;
	logic [REM_W+1:0]  y_op;
	logic [REM_W+2:0]  diff;
	logic              ge;

	// root: trial = 4*rem + next pair vs 4*root + 1
	// div:  trial = 2*rem + next bit vs divisor
	always_comb begin
		if (op_q == CSU_ROOT) begin
			x_op = {rem_q, src_q[SRC_W-1 -: 2]};
			y_op = {2'b00, res_q[RES_W-2:0], 2'b01};
		end else begin
			x_op = {2'b00, rem_q[REM_W-2:0], src_q[SRC_W-1]};
			y_op = {(REM_W+2-SUM_W)'(0), div_q};
		end
		diff = {1'b0, x_op} - {1'b0, y_op};
		ge   = ~diff[REM_W+2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			cnt_q <= req.steps;
			src_q <= req.src;
			rem_q <= req.rem_init;
			res_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			rem_q <= ge ? diff[REM_W-1:0] : x_op[REM_W-1:0];
			res_q <= {res_q[RES_W-2:0], ge};
			if (op_q == CSU_ROOT)
				src_q <= {src_q[SRC_W-3:0], 2'b00};
			else
				src_q <= {src_q[SRC_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

/* hdl/windowed_mean_stability_monitor_unit.sv */
// Top level of the windowed mean / stability monitor: sample ring, running
// sums, sequencer and output register. Depends on wmsm_pkg, wmsm_mul, wmsm_csu.
//
//  channel | direction | word                                   | handshake
//  --------+-----------+----------------------------------------+----------------
//  s_*     | in        | rate_sample                            | tvalid & tready
//  m_*     | out       | window_mean, stability, samples_held   | tvalid & tready
//
// Per sample, accept to next accept: the accept cycle, the states for ring access,
// sum update and products, then the shared compare-subtract unit runs the mean
// division (24 steps), the square root (31) and the ratio division (20), each
// followed by a done cycle, and S_OUT loads the output register. Fewer than two
// samples or a zero sum skip root and ratio; a saturated ratio skips the ratio
// division. s_tready is high only while the sequencer is idle; a finished word
// waits in the output register and the next sample is taken while it waits.
// Reset clears fill count, write slot and sums; no clearing pass.
module windowed_mean_stability_monitor_unit
	import wmsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] rate_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [23:0] window_mean, [43:24] stability,
	                               // [50:44] samples_held, [55:51] zero
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RD     = 4'd1;   // ring read, x*x
	localparam logic [3:0] S_UPD1   = 4'd2;   // add x, x^2; old*old
	localparam logic [3:0] S_UPD2   = 4'd3;   // remove old^2; sum*sum
	localparam logic [3:0] S_M1     = 4'd4;   // count*sumsq low part
	localparam logic [3:0] S_M2     = 4'd5;   // count*sumsq high part
	localparam logic [3:0] S_M3     = 4'd6;   // combine partial products
	localparam logic [3:0] S_D      = 4'd7;   // variance term, start mean div
	localparam logic [3:0] S_MEAN_W = 4'd8;
	localparam logic [3:0] S_ROOT_W = 4'd9;
	localparam logic [3:0] S_SAT    = 4'd10;  // saturation check
	localparam logic [3:0] S_DIV_W  = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	localparam logic [STAB_W-1:0] STAB_ONE = STAB_W'(65536);
	localparam logic [STAB_W-1:0] STAB_MIN = STAB_W'(-524288);
	localparam int               LO_W     = 27;  // low split of sumsq

	logic [3:0]          state_q;
	logic [SAMPLE_W-1:0] ring [WINDOW];
	logic [SAMPLE_W-1:0] x_q;
	logic [SAMPLE_W-1:0] old_q;
	logic                full_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sumsq_q;
	logic [60:0]         a_q;      // count * sumsq
	logic [59:0]         b_q;      // sum^2
	logic [60:0]         d_q;      // count*sumsq - sum^2
	logic [RES_W-1:0]    r_q;      // integer root
	logic [SAMPLE_W-1:0] mean_q;
	logic [STAB_W-1:0]   stab_q;

	logic                m_valid_q;
	logic [55:0]         m_data_q;

	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [2*MUL_W-1:0]  mul_p;
	csu_req_t            csu_req;
	csu_rsp_t            csu_rsp;
	logic [SUM_W+3:0]    nine_sum;
	logic                out_free;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign nine_sum = {1'b0, sum_q, 3'b000} + (SUM_W+4)'(sum_q);

	wmsm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	wmsm_csu u_csu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (csu_req),
		.rsp    (csu_rsp)
	);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_RD: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			S_UPD1: begin
				mul_a = MUL_W'(old_q);
				mul_b = MUL_W'(old_q);
			end
			S_UPD2: begin
				mul_a = MUL_W'(sum_q);
				mul_b = MUL_W'(sum_q);
			end
			S_M1: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(sumsq_q[LO_W-1:0]);
			end
			S_M2: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(sumsq_q[SQ_W-1:LO_W]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// requests to the compare-subtract unit
	always_comb begin
		csu_req = '0;
		case (state_q)
			S_D: begin
				// mean: quotient fits 24 bits, so start from sum >> 24
				csu_req.start    = 1'b1;
				csu_req.op       = CSU_DIV;
				csu_req.src      = {sum_q[SAMPLE_W-1:0], (SRC_W-SAMPLE_W)'(0)};
				csu_req.rem_init = REM_W'(sum_q[SUM_W-1:SAMPLE_W]);
				csu_req.divisor  = SUM_W'(count_q);
				csu_req.steps    = STEP_W'(SAMPLE_W);
			end
			S_MEAN_W: begin
				if (csu_rsp.done && count_q >= CNT_W'(2) && sum_q != '0) begin
					csu_req.start    = 1'b1;
					csu_req.op       = CSU_ROOT;
					csu_req.src      = {1'b0, d_q};
					csu_req.rem_init = '0;
					csu_req.divisor  = '0;
					csu_req.steps    = STEP_W'(SRC_W/2);
				end
			end
			S_SAT: begin
				// (r << 16) / sum with a 20-bit quotient: start from r >> 4
				if ({3'b000, r_q} < nine_sum) begin
					csu_req.start    = 1'b1;
					csu_req.op       = CSU_DIV;
					csu_req.src      = {r_q[3:0], (SRC_W-4)'(0)};
					csu_req.rem_init = REM_W'(r_q[RES_W-1:4]);
					csu_req.divisor  = sum_q;
					csu_req.steps    = STEP_W'(STAB_W);
				end
			end
			default: csu_req = '0;
		endcase
	end

	// ring memory: read old entry, then overwrite with the new sample
	always_ff @(posedge clk) begin
		if (state_q == S_RD)
			old_q <= ring[slot_q];
		if (state_q == S_UPD1)
			ring[slot_q] <= x_q;
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			slot_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			sumsq_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// a new word replaces a taken one in the same cycle
			if (state_q == S_OUT && out_free)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_RD;
				end
				S_RD: state_q <= S_UPD1;
				S_UPD1: begin
					sum_q   <= sum_q + SUM_W'(x_q) - (full_q ? SUM_W'(old_q) : '0);
					sumsq_q <= sumsq_q + SQ_W'(mul_p[2*SAMPLE_W-1:0]);
					if (!full_q)
						count_q <= count_q + CNT_W'(1);
					if (slot_q == SLOT_W'(WINDOW-1))
						slot_q <= '0;
					else
						slot_q <= slot_q + SLOT_W'(1);
					state_q <= S_UPD2;
				end
				S_UPD2: begin
					if (full_q)
						sumsq_q <= sumsq_q - SQ_W'(mul_p[2*SAMPLE_W-1:0]);
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_D;
				S_D: state_q <= S_MEAN_W;
				S_MEAN_W: begin
					if (csu_rsp.done) begin
						if (count_q < CNT_W'(2) || sum_q == '0)
							state_q <= S_OUT;
						else
							state_q <= S_ROOT_W;
					end
				end
				S_ROOT_W: begin
					if (csu_rsp.done)
						state_q <= S_SAT;
				end
				S_SAT: begin
					if ({3'b000, r_q} >= nine_sum)
						state_q <= S_OUT;
					else
						state_q <= S_DIV_W;
				end
				S_DIV_W: begin
					if (csu_rsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					x_q <= s_tdata[SAMPLE_W-1:0];
				full_q <= (count_q >= CNT_W'(WINDOW));
			end
			S_M1: b_q <= mul_p[59:0];
			S_M2: a_q <= mul_p[60:0];
			S_M3: a_q <= a_q + {mul_p[60-LO_W:0], LO_W'(0)};
			S_D: d_q <= (a_q > {1'b0, b_q}) ? (a_q - {1'b0, b_q}) : '0;
			S_MEAN_W: begin
				if (csu_rsp.done) begin
					mean_q <= csu_rsp.res[SAMPLE_W-1:0];
					if (count_q < CNT_W'(2))
						stab_q <= STAB_ONE;
					else
						stab_q <= '0;
				end
			end
			S_ROOT_W: begin
				if (csu_rsp.done)
					r_q <= csu_rsp.res;
			end
			S_SAT: begin
				if ({3'b000, r_q} >= nine_sum)
					stab_q <= STAB_MIN;
			end
			S_DIV_W: begin
				if (csu_rsp.done)
					stab_q <= STAB_ONE - csu_rsp.res[STAB_W-1:0];
			end
			S_OUT: begin
				if (out_free)
					m_data_q <= {5'b00000, count_q, stab_q, mean_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---- assertions ----
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		csu_rsp.done |-> (state_q == S_MEAN_W || state_q == S_ROOT_W
			|| state_q == S_DIV_W))
		else $error("csu result arrived while sequencer was not waiting");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("fill count above window depth");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[50:44] != '0 && m_tdata[50:44] <= CNT_W'(WINDOW)))
		else $error("samples_held out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_RD))
		else $error("accepted sample did not start the sequence");

endmodule

/* bench/tb_windowed_mean_stability_monitor_unit.sv */
// Self-checking bench for windowed_mean_stability_monitor_unit: directed table, then random runs
// of rate samples, each output word checked against the table or a local window model.
// Depends on wmsm_pkg and the RTL under hdl/.
module tb_windowed_mean_stability_monitor_unit
	import wmsm_pkg::*;
();

	// Q4.16 stability bounds
	localparam int STAB_ONE   = 65536;
	localparam int STAB_FLOOR = -524288;

	// random part: three phases of equal size, each with its own idle pattern
	localparam int RANDOM_ITEMS   = 1284;
	localparam int SEND_IDLE  [3] = '{8, 49, 0};
	localparam int RECV_STALL [3] = '{49, 8, 0};
	localparam int HOLD_CYCLES    = 400;   // long sink hold-off, several sample times
	localparam int QUIET_LIMIT    = 5000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 200;   // about two sample times

	// output word as it sits in m_tdata, lowest field last in the declaration
	typedef struct packed {
		logic [CNT_W-1:0]         held;
		logic signed [STAB_W-1:0] stab;
		logic [SAMPLE_W-1:0]      mean;
	} stat_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                typed;    // want holds the expected word
		stat_word_t          want;
	} dir_row_t;

	typedef enum int {
		RUN_SPREAD,   // full-range samples
		RUN_STEADY,   // narrow jitter around a base rate
		RUN_FLAT,     // constant rate, zero deviation
		RUN_SPIKES,   // mostly zero, rare large samples: deepest negative stability
		RUN_ZEROS,    // zero sum once the window holds only zeros
		RUN_TINY      // 0..3, small sums and quotients
	} run_kind_t;

	// Directed rows. Only the first words after reset are typed in; the rest go
	// through the model. Zero, all ones, single bits and alternating patterns.
	localparam int DIR_ROWS = 15;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{24'h000000, 1'b1, '{7'd1, 20'sd65536, 24'd0}},  // one sample: stability 1.0
		'{24'h000000, 1'b1, '{7'd2, 20'sd0, 24'd0}},      // zero sum: stability 0
		'{24'hFFFFFF, 1'b0, '0},
		'{24'hFFFFFF, 1'b0, '0},
		'{24'h000001, 1'b0, '0},
		'{24'hAAAAAA, 1'b0, '0},
		'{24'h555555, 1'b0, '0},
		'{24'h800000, 1'b0, '0},
		'{24'h7FFFFF, 1'b0, '0},
		'{24'h000000, 1'b0, '0},
		'{24'hFFFFFE, 1'b0, '0},
		'{24'h123456, 1'b0, '0},
		'{24'hFEDCBA, 1'b0, '0},
		'{24'h000100, 1'b0, '0},
		'{24'h010000, 1'b0, '0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	// window model state, same widths as the block
	logic [SAMPLE_W-1:0] window_ring [WINDOW];
	logic [SLOT_W-1:0]   next_slot = '0;
	logic [CNT_W-1:0]    held_now  = '0;
	logic [SUM_W-1:0]    sum_now   = '0;
	logic [SQ_W-1:0]     sumsq_now = '0;

	stat_word_t pending_stats [$];   // expected words, oldest first
	int mismatch_count = 0;
	int words_checked  = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_token     = 0;          // bumped by the driver to request a sink hold-off

	windowed_mean_stability_monitor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Take one sample into the window model and return the word it should produce.
	// Stability is 1 - sqrt(n*sumsq - sum^2)/sum in Q4.16, done on integers.
	function automatic stat_word_t advance_window(input logic [SAMPLE_W-1:0] x);
		logic [63:0] oldest, sq_term, spread, root, trial, ratio;
		int bitpos;
		stat_word_t w;
		// full ring: drop the oldest sample before the new one lands on its slot
		if (held_now >= CNT_W'(WINDOW)) begin
			oldest = 64'(window_ring[next_slot]);
			sum_now = sum_now - SUM_W'(oldest);
			sumsq_now = sumsq_now - SQ_W'(oldest * oldest);
		end else begin
			held_now = held_now + 1'b1;
		end
		window_ring[next_slot] = x;
		sum_now = sum_now + SUM_W'(x);
		sumsq_now = sumsq_now + SQ_W'(64'(x) * 64'(x));
		next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;

		w.mean = SAMPLE_W'(64'(sum_now) / 64'(held_now));
		w.held = held_now;
		if (held_now < 2) begin
			w.stab = STAB_W'(STAB_ONE);
		end else if (sum_now == '0) begin
			w.stab = '0;
		end else begin
			sq_term = 64'(held_now) * 64'(sumsq_now);
			spread = 64'(sum_now) * 64'(sum_now);
			spread = (sq_term > spread) ? sq_term - spread : 64'd0;
			// floor root, one result bit at a time from the top (radicand < 2^62)
			root = '0;
			for (bitpos = 31; bitpos >= 0; bitpos--) begin
				trial = root | (64'd1 << bitpos);
				if (trial * trial <= spread)
					root = trial;
			end
			ratio = (root << 16) / 64'(sum_now);
			if (ratio >= 64'(STAB_ONE - STAB_FLOOR))
				w.stab = STAB_W'(STAB_FLOOR);
			else
				w.stab = STAB_W'(longint'(STAB_ONE) - longint'(ratio));
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("word %0d: %s got %0d expected %0d", words_checked, what, got, want);
		mismatch_count++;
	endtask

	// Offer one sample, with random idle cycles ahead of it, and log its expected word
	// once the block takes it. typed selects the table word over the model word.
	task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic typed,
			input stat_word_t fixed);
		stat_word_t w;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		// s_tready read right after the edge is its value at the edge
		do @(posedge clk); while (!s_tready);
		w = advance_window(x);
		pending_stats.insert(pending_stats.size(), typed ? fixed : w);
	endtask

	// Sink: check each accepted word, then pick m_tready for the next cycle.
	always @(posedge clk) begin : sink
		stat_word_t got, want;
		int hold_seen = 0;
		int hold_left = 0;
		if (m_tvalid && m_tready) begin
			got = stat_word_t'(m_tdata[$bits(stat_word_t)-1:0]);
			if (pending_stats.size() == 0) begin
				report_mismatch("word with nothing pending, mean", got.mean, 0);
			end else begin
				want = pending_stats.pop_front();
				if (got.mean != want.mean)
					report_mismatch("window_mean", got.mean, want.mean);
				if (got.stab != want.stab)
					report_mismatch("stability", got.stab, want.stab);
				if (got.held != want.held)
					report_mismatch("samples_held", got.held, want.held);
			end
			words_checked++;
		end
		// a long hold-off lets the output register and the sequencer fill up,
		// so s_tready drops while the driver keeps offering
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	always @(posedge clk) begin : watchdog
		int quiet = 0;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("tb_windowed_mean_stability_monitor_unit NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int sent, phase_end, run_left, phase;
		logic [SAMPLE_W-1:0] run_base, x;
		run_kind_t kind;
		sent = 0;
		run_left = 0;
		run_base = '0;
		kind = RUN_SPREAD;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_sample(DIRECTED[r].sample, DIRECTED[r].typed, DIRECTED[r].want);

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			recv_stall_pct <= RECV_STALL[phase];
			if (phase == 2)
				hold_token <= hold_token + 1;
			phase_end = sent + RANDOM_ITEMS / 3;
			// open with a full window of zeros so the zero-sum case is reached
			if (phase == 0) begin
				kind = RUN_ZEROS;
				run_left = WINDOW + 6;
			end
			while (sent < phase_end) begin
				if (run_left == 0) begin
					kind = run_kind_t'($urandom_range(0, 5));
					run_left = $urandom_range(16, 80);
					run_base = SAMPLE_W'($urandom_range(0, 24'hFFFF00));
				end
				case (kind)
					RUN_SPREAD: x = SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
					RUN_STEADY: x = run_base + SAMPLE_W'($urandom_range(0, 255));
					RUN_FLAT:   x = run_base;
					RUN_SPIKES: begin
						if ($urandom_range(0, 15) != 0)
							x = '0;
						else if ($urandom_range(0, 1) != 0)
							x = 24'hFFFFFF;
						else
							x = SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
					end
					RUN_ZEROS:  x = '0;
					default:    x = SAMPLE_W'($urandom_range(0, 3));
				endcase
				send_sample(x, 1'b0, '0);
				sent++;
				run_left--;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_windowed_mean_stability_monitor_unit OK");
		else
			$display("tb_windowed_mean_stability_monitor_unit NOT OK");
		$finish;
	end

endmodule
